/* rtl/scp_pkg.sv */
// Shared types and constants of the serial command parser.
package scp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_AUTH      = 3'd1,
    MODE_RESET     = 3'd2,
    MODE_DSETMODE  = 3'd3,
    MODE_DCHAR     = 3'd4,
    MODE_SNORMAL   = 3'd5,
    MODE_SSPECIAL  = 3'd6,
    MODE_SHEX      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_GLYPH   = 3'd1,
    ACT_COLUMN  = 3'd2,
    ACT_MODE    = 3'd3,
    ACT_WRITE   = 3'd4,
    ACT_RESTART = 3'd5
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data;
    logic [7:0] address;
  } result_t;

  localparam int MaxResults = 3;
  localparam int CountBits  = 2;

  localparam logic [7:0] CharEsc     = 8'd27;
  localparam logic [7:0] CharH       = 8'h48;
  localparam logic [7:0] CharL       = 8'h4C;
  localparam logic [7:0] CharD       = 8'h44;
  localparam logic [7:0] CharCr      = 8'd13;
  localparam logic [7:0] CharLf      = 8'd10;
  localparam logic [7:0] CharCaret   = 8'h5E;
  localparam logic [7:0] CharDollar  = 8'h24;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] HexLetterGap = 8'h41 - 8'h39 - 8'd1;
  localparam logic [7:0] SpecialOffset = 8'd63;
  localparam logic [7:0] LogoGlyph   = 8'd129;
  localparam logic [7:0] MaxDigit    = 8'd15;

  localparam logic [2:0] RegMessageStart = 3'd0;

endpackage

/* rtl/serial_command_parser_unit.sv */
// Top level of the serial command parser: input register, parser state and result buffer.
// Each byte accepted on the s_ side is held in an input register and decoded combinationally
// into up to three results, which are loaded into a result buffer and sent one per cycle on
// the m_ side while m_tready is high, the final one of each byte marked by m_tlast. A byte that
// yields no result (framing error, or a byte that only moves the parser) leaves the input register
// without waiting for the result buffer; a byte that yields k results holds the result buffer until
// all k have been taken, so the sustained rate is at most one byte per cycle, set by the single output port.
// The next byte is taken while results of the previous one are still being delivered.
// message_start is written through the APB port at any address with paddr[2] clear and read at address 0.
module serial_command_parser_unit #(
  parameter int ADDR_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte [7:0]
  input  logic        s_tuser,   // framing_error [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // action [2:0], data [10:3], address [18:11], zero [23:19]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]            message_start;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_ferr;
  logic                  in_consume;
  scp_pkg::mode_t        mode;
  scp_pkg::mode_t        mode_next;
  logic [7:0]            hex_value;
  logic [7:0]            hex_value_next;
  logic [ADDR_BITS-1:0]  write_address;
  logic [ADDR_BITS-1:0]  write_address_next;
  scp_pkg::result_t      dec_results [scp_pkg::MaxResults];
  logic [scp_pkg::CountBits-1:0] dec_count;
  scp_pkg::result_t      res [scp_pkg::MaxResults];
  logic [scp_pkg::CountBits-1:0] res_count;
  logic [scp_pkg::CountBits-1:0] res_index;
  logic                  res_valid;
  logic                  res_last;
  logic                  res_free;
  scp_pkg::result_t      cur;

  assign pready = 1'b1;
  assign prdata = (paddr == scp_pkg::RegMessageStart) ? {24'd0, message_start} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_start <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      message_start <= pwdata[7:0];
    end
  end

  scp_decode #(
    .ADDR_BITS(ADDR_BITS)
  ) u_decode (
    .rx_byte            (in_byte),
    .framing_error      (in_ferr),
    .mode               (mode),
    .hex_value          (hex_value),
    .write_address      (write_address),
    .message_start      (message_start),
    .results            (dec_results),
    .count              (dec_count),
    .mode_next          (mode_next),
    .hex_value_next     (hex_value_next),
    .write_address_next (write_address_next)
  );

  assign res_last   = (res_index == res_count - 1'b1);
  assign res_free   = !res_valid || (m_tready && res_last);
  assign in_consume = in_valid && ((dec_count == '0) || res_free);
  assign s_tready   = !in_valid || in_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_ferr <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= scp_pkg::MODE_IDLE;
      hex_value     <= 8'd0;
      write_address <= '0;
    end else if (in_consume) begin
      mode          <= mode_next;
      hex_value     <= hex_value_next;
      write_address <= write_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_index <= '0;
      res_count <= '0;
    end else if (in_consume && dec_count != '0) begin
      res_valid <= 1'b1;
      res_index <= '0;
      res_count <= dec_count;
    end else if (res_valid && m_tready) begin
      if (res_last) begin
        res_valid <= 1'b0;
        res_index <= '0;
      end else begin
        res_index <= res_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_consume && dec_count != '0) begin
      res <= dec_results;
    end
  end

  always_comb begin
    case (res_index)
      2'd0:    cur = res[0];
      2'd1:    cur = res[1];
      2'd2:    cur = res[2];
      default: cur = res[0];
    endcase
  end

  assign m_tvalid = res_valid;
  assign m_tlast  = res_last;
  assign m_tdata  = {5'd0, cur.address, cur.data, cur.action};

endmodule

/* rtl/scp_decode.sv */
// Combinational decode of one received byte into results and the next parser state.
module scp_decode #(
  parameter int ADDR_BITS = 8
) (
  input  logic [7:0]            rx_byte,
  input  logic                  framing_error,
  input  scp_pkg::mode_t        mode,
  input  logic [7:0]            hex_value,
  input  logic [ADDR_BITS-1:0]  write_address,
  input  logic [7:0]            message_start,
  output scp_pkg::result_t      results [scp_pkg::MaxResults],
  output logic [scp_pkg::CountBits-1:0] count,
  output scp_pkg::mode_t        mode_next,
  output logic [7:0]            hex_value_next,
  output logic [ADDR_BITS-1:0]  write_address_next
);

  scp_pkg::mode_t eff_mode;
  logic [7:0]     digit_a;
  logic [7:0]     digit;
  logic           is_digit;
  logic           is_eol;
  logic           do_store;
  logic [7:0]     store_value;

  assign is_eol = (rx_byte == scp_pkg::CharCr) || (rx_byte == scp_pkg::CharLf);
  assign digit_a = (rx_byte >= scp_pkg::CharUpperA) ? rx_byte - scp_pkg::HexLetterGap : rx_byte;
  assign digit = digit_a - scp_pkg::CharZero;
  assign is_digit = (digit <= scp_pkg::MaxDigit);

  always_comb begin
    eff_mode = (rx_byte == scp_pkg::CharEsc) ? scp_pkg::MODE_RESET : mode;
    for (int i = 0; i < scp_pkg::MaxResults; i++) begin
      results[i] = '{action: scp_pkg::ACT_CLEAR, data: 8'd0, address: 8'd0};
    end
    count = '0;
    mode_next = mode;
    hex_value_next = hex_value;
    write_address_next = write_address;
    do_store = 1'b0;
    store_value = rx_byte;

    if (!framing_error) begin
      mode_next = eff_mode;
      case (eff_mode)
        scp_pkg::MODE_IDLE: begin
          mode_next = (rx_byte == scp_pkg::CharH) ? scp_pkg::MODE_AUTH : scp_pkg::MODE_IDLE;
        end
        scp_pkg::MODE_AUTH: begin
          if (rx_byte == scp_pkg::CharL) begin
            mode_next = scp_pkg::MODE_SNORMAL;
          end else if (rx_byte == scp_pkg::CharD) begin
            mode_next = scp_pkg::MODE_DSETMODE;
          end else begin
            mode_next = scp_pkg::MODE_IDLE;
          end
        end
        scp_pkg::MODE_RESET: begin
          results[0] = '{action: scp_pkg::ACT_RESTART, data: 8'd0, address: message_start};
          results[2] = '{action: scp_pkg::ACT_GLYPH, data: scp_pkg::LogoGlyph, address: 8'd0};
          count = 2'd3;
          write_address_next = ADDR_BITS'(message_start);
          mode_next = scp_pkg::MODE_IDLE;
        end
        scp_pkg::MODE_DSETMODE: begin
          results[1] = '{action: scp_pkg::ACT_MODE, data: rx_byte, address: 8'd0};
          count = 2'd2;
          mode_next = scp_pkg::MODE_DCHAR;
        end
        scp_pkg::MODE_DCHAR: begin
          if (is_eol) begin
            count = 2'd1;
          end else begin
            results[0] = '{action: scp_pkg::ACT_GLYPH, data: rx_byte, address: 8'd0};
            results[1] = '{action: scp_pkg::ACT_COLUMN, data: 8'd0, address: 8'd0};
            count = 2'd2;
          end
        end
        scp_pkg::MODE_SNORMAL: begin
          if (rx_byte == scp_pkg::CharCaret) begin
            mode_next = scp_pkg::MODE_SSPECIAL;
          end else if (rx_byte == scp_pkg::CharDollar) begin
            hex_value_next = 8'd0;
            mode_next = scp_pkg::MODE_SHEX;
          end else if (is_eol) begin
            do_store = 1'b1;
            store_value = 8'd0;
          end else if (rx_byte >= scp_pkg::CharSpace) begin
            do_store = 1'b1;
          end
        end
        scp_pkg::MODE_SSPECIAL: begin
          do_store = 1'b1;
          store_value = rx_byte + scp_pkg::SpecialOffset;
          mode_next = scp_pkg::MODE_SNORMAL;
        end
        scp_pkg::MODE_SHEX: begin
          if (is_digit) begin
            hex_value_next = {hex_value[3:0], digit[3:0]};
          end else begin
            do_store = 1'b1;
            store_value = hex_value;
            mode_next = scp_pkg::MODE_SNORMAL;
          end
        end
        default: begin
          mode_next = scp_pkg::MODE_IDLE;
        end
      endcase

      if (eff_mode == scp_pkg::MODE_SNORMAL || eff_mode == scp_pkg::MODE_SSPECIAL ||
          eff_mode == scp_pkg::MODE_SHEX) begin
        results[1] = '{action: scp_pkg::ACT_GLYPH, data: rx_byte, address: 8'd0};
        count = 2'd2;
        if (do_store) begin
          results[2] = '{action: scp_pkg::ACT_WRITE, data: store_value,
                         address: write_address[7:0]};
          count = 2'd3;
          write_address_next = write_address + 1'b1;
        end
      end
    end
  end

endmodule

/* tb/tb_serial_command_parser_unit.sv */
// Self-checking testbench for the serial command parser with directed and random byte streams.
`timescale 1ns / 100ps

module tb_serial_command_parser_unit;
  import scp_pkg::*;

  localparam int AddrBits = 8;
  localparam logic [2:0] MsgStartAddr = RegMessageStart << 2;

  typedef struct {
    action_t    action;
    logic [7:0] data;
    logic [7:0] address;
    logic       last;
  } display_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // rx_byte [7:0]
  logic        s_tuser = 1'b0; // framing_error [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // action [2:0], data [10:3], address [18:11], zero [23:19]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mode_t                parse_mode = MODE_IDLE;
  logic [7:0]           hex_acc = '0;
  logic [AddrBits-1:0]  store_addr = '0;
  logic [7:0]           base_addr = '0;

  display_op_t pending_ops[$];
  display_op_t byte_ops[3];
  int          byte_count;
  int          error_count = 0;
  int          sent_count = 0;
  bit          no_idle = 1'b0;

  serial_command_parser_unit #(.ADDR_BITS(AddrBits)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void add_op(action_t a, logic [7:0] dat, logic [7:0] adr);
    byte_ops[byte_count].action = a;
    byte_ops[byte_count].data = dat;
    byte_ops[byte_count].address = adr;
    byte_ops[byte_count].last = 1'b0;
    byte_count++;
  endfunction

  function automatic void store_value(logic [7:0] v);
    add_op(ACT_WRITE, v, store_addr[7:0]);
    store_addr = store_addr + 1'b1;
  endfunction

  function automatic void decode_byte(logic [7:0] ch, logic fe);
    logic [7:0] d;
    byte_count = 0;
    if (fe) return;
    if (ch == CharEsc) parse_mode = MODE_RESET;
    if (parse_mode >= MODE_SNORMAL) begin
      add_op(ACT_CLEAR, 8'd0, 8'd0);
      add_op(ACT_GLYPH, ch, 8'd0);
    end
    case (parse_mode)
      MODE_IDLE: begin
        if (ch == CharH) parse_mode = MODE_AUTH;
      end
      MODE_AUTH: begin
        if (ch == CharL) parse_mode = MODE_SNORMAL;
        else if (ch == CharD) parse_mode = MODE_DSETMODE;
        else parse_mode = MODE_IDLE;
      end
      MODE_RESET: begin
        add_op(ACT_RESTART, 8'd0, base_addr);
        store_addr = base_addr;
        add_op(ACT_CLEAR, 8'd0, 8'd0);
        add_op(ACT_GLYPH, LogoGlyph, 8'd0);
        parse_mode = MODE_IDLE;
      end
      MODE_DSETMODE: begin
        add_op(ACT_CLEAR, 8'd0, 8'd0);
        add_op(ACT_MODE, ch, 8'd0);
        parse_mode = MODE_DCHAR;
      end
      MODE_DCHAR: begin
        if (ch == CharCr || ch == CharLf) begin
          add_op(ACT_CLEAR, 8'd0, 8'd0);
        end else begin
          add_op(ACT_GLYPH, ch, 8'd0);
          add_op(ACT_COLUMN, 8'd0, 8'd0);
        end
      end
      MODE_SNORMAL: begin
        if (ch == CharCaret) begin
          parse_mode = MODE_SSPECIAL;
        end else if (ch == CharDollar) begin
          hex_acc = 8'd0;
          parse_mode = MODE_SHEX;
        end else if (ch == CharCr || ch == CharLf) begin
          store_value(8'd0);
        end else if (ch >= CharSpace) begin
          store_value(ch);
        end
      end
      MODE_SSPECIAL: begin
        store_value(ch + SpecialOffset);
        parse_mode = MODE_SNORMAL;
      end
      default: begin
        d = ch;
        if (d >= CharUpperA) d = d - HexLetterGap;
        d = d - CharZero;
        if (d > MaxDigit) begin
          store_value(hex_acc);
          parse_mode = MODE_SNORMAL;
        end else begin
          hex_acc = {hex_acc[3:0], 4'b0000} + d;
        end
      end
    endcase
    for (int i = 0; i < byte_count; i++) begin
      byte_ops[i].last = (i == byte_count - 1);
      pending_ops.push_back(byte_ops[i]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic fe);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= fe;
    do @(posedge clk); while (!s_tready);
    decode_byte(ch, fe);
  endtask

  task automatic feed(input logic [7:0] ch);
    if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(ch, 1'b0);
    sent_count++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_message_start(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MsgStartAddr;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    base_addr = value;
  endtask

  function automatic logic [7:0] hex_char(int n);
    logic [7:0] c;
    if (n < 10) c = CharZero + 8'(n);
    else c = CharUpperA + 8'(n - 10);
    return c;
  endfunction

  task automatic test_framing_errors();
    send_byte(CharEsc, 1'b1);
    send_byte(CharH, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(CharEsc, 1'b0);
  endtask

  task automatic test_wrong_h_sequence();
    send_byte(CharH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CharH, 1'b0);
    send_byte(CharH, 1'b0);
  endtask

  task automatic test_display_mode();
    send_byte(CharH, 1'b0);
    send_byte(CharD, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharLf, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(CharEsc, 1'b0);
  endtask

  task automatic test_store_mode_wrap();
    wait_idle();
    write_message_start(8'hFF);
    send_byte(CharEsc, 1'b0);
    send_byte(CharH, 1'b0);
    send_byte(CharL, 1'b0);
    send_byte(CharSpace, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharCaret, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CharDollar, 1'b0);
    send_byte(8'h39, 1'b0);
    send_byte(8'h46, 1'b0);
    send_byte(8'h47, 1'b0);
    send_byte(CharDollar, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(CharEsc, 1'b0);
    wait_idle();
    write_message_start(8'h00);
  endtask

  task automatic test_random_traffic();
    int kind;
    int len;
    int r;
    int digits;
    logic [7:0] base;
    while (sent_count < 400) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        wait_idle();
        r = $urandom_range(0, 3);
        base = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        write_message_start(base);
        feed(CharEsc);
      end else if (kind <= 3) begin
        feed(CharEsc);
        feed(CharH);
        feed(CharD);
        feed(8'($urandom_range(0, 255)));
        len = $urandom_range(2, 10);
        repeat (len) begin
          r = $urandom_range(0, 7);
          if (r == 0) feed(CharCr);
          else if (r == 1) feed(CharLf);
          else feed(8'($urandom_range(0, 255)));
        end
      end else if (kind <= 8) begin
        if ($urandom_range(0, 3) != 0) feed(CharEsc);
        feed(CharH);
        feed(CharL);
        len = $urandom_range(4, 20);
        repeat (len) begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            feed(CharCaret);
            feed(8'($urandom_range(0, 255)));
          end else if (r == 1) begin
            feed(CharDollar);
            digits = $urandom_range(0, 3);
            repeat (digits) feed(hex_char($urandom_range(0, 15)));
            feed(8'($urandom_range(0, 255)));
          end else if (r == 2) begin
            feed(($urandom_range(0, 1) == 0) ? CharCr : CharLf);
          end else if (r == 3) begin
            feed(8'($urandom_range(0, 255)));
          end else begin
            feed(8'($urandom_range(32, 126)));
          end
        end
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          r = $urandom_range(0, 1);
          send_byte(8'($urandom_range(0, 255)), r[0]);
          if (r == 0) sent_count++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    display_op_t want;
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_ops.size() == 0) begin
        $error("unexpected result transaction: tdata %h tlast %b", m_tdata, m_tlast);
        error_count++;
      end else begin
        want = pending_ops.pop_front();
        if (m_tdata[2:0] !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, m_tdata[2:0]);
          error_count++;
        end
        if (m_tdata[10:3] !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, m_tdata[10:3]);
          error_count++;
        end
        if (m_tdata[18:11] !== want.address) begin
          $error("address: expected %0d, got %0d", want.address, m_tdata[18:11]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_framing_errors();
    test_wrong_h_sequence();
    test_display_mode();
    test_store_mode_wrap();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("** serial_command_parser_unit: PASSED **");
    end else begin
      $display("** serial_command_parser_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** serial_command_parser_unit: FAILED **");
    $finish;
  end

endmodule
